>>> rtl/mwe_pkg.sv
// Shared types, request codes and the segment programmes of the Microwire EEPROM master.
`timescale 1ns / 1ps

package mwe_pkg;

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_WRITE   = 2'd2;
    localparam logic [1:0] REQ_UNPROT  = 2'd3;

    // Start bit followed by the two opcode bits.
    localparam logic [2:0] OP_READ  = 3'b110;
    localparam logic [2:0] OP_WRITE = 3'b101;
    localparam logic [2:0] OP_EXT   = 3'b100;
    localparam logic [2:0] OP_PCLR  = 3'b111;

    localparam logic [2:0] SEG_END = 3'd0;
    localparam logic [2:0] SEG_SH  = 3'd1;
    localparam logic [2:0] SEG_RD  = 3'd2;
    localparam logic [2:0] SEG_DS  = 3'd3;
    localparam logic [2:0] SEG_PL  = 3'd4;

    localparam logic [1:0] SRC_MAIN = 2'd0;
    localparam logic [1:0] SRC_EWEN = 2'd1;
    localparam logic [1:0] SRC_EWDS = 2'd2;
    localparam logic [1:0] SRC_PCLR = 2'd3;

    localparam int CMD_MAX_W = 27;
    localparam int STEP_W    = 4;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] src;
        logic       pr;
    } seg_t;

    typedef struct packed {
        logic [1:0]           req;
        logic [CMD_MAX_W-1:0] cmd;
        logic                 din;
    } item_t;

    typedef struct packed {
        logic pr;
        logic de;
        logic dout;
        logic clk;
        logic cs;
    } pins_t;

    function automatic seg_t mk_seg(input logic [2:0] kind, input logic [1:0] src,
                                    input logic pr);
        seg_t s;
        s.kind = kind;
        s.src  = src;
        s.pr   = pr;
        return s;
    endfunction

    function automatic seg_t prog_seg(input logic [1:0] req, input logic [STEP_W-1:0] step);
        seg_t s;
        s = mk_seg(SEG_END, SRC_MAIN, 1'b0);
        unique case (req)
            REQ_READ: begin
                unique case (step)
                    4'd0: s = mk_seg(SEG_SH, SRC_MAIN, 1'b0);
                    4'd1: s = mk_seg(SEG_RD, SRC_MAIN, 1'b0);
                    4'd2: s = mk_seg(SEG_DS, SRC_MAIN, 1'b0);
                    default: s = mk_seg(SEG_END, SRC_MAIN, 1'b0);
                endcase
            end
            REQ_WRITE: begin
                unique case (step)
                    4'd0: s = mk_seg(SEG_SH, SRC_EWEN, 1'b0);
                    4'd1: s = mk_seg(SEG_DS, SRC_MAIN, 1'b0);
                    4'd2: s = mk_seg(SEG_SH, SRC_MAIN, 1'b0);
                    4'd3: s = mk_seg(SEG_DS, SRC_MAIN, 1'b0);
                    4'd4: s = mk_seg(SEG_PL, SRC_MAIN, 1'b0);
                    4'd5: s = mk_seg(SEG_DS, SRC_MAIN, 1'b0);
                    4'd6: s = mk_seg(SEG_SH, SRC_EWDS, 1'b0);
                    4'd7: s = mk_seg(SEG_DS, SRC_MAIN, 1'b0);
                    default: s = mk_seg(SEG_END, SRC_MAIN, 1'b0);
                endcase
            end
            REQ_UNPROT: begin
                unique case (step)
                    4'd0: s = mk_seg(SEG_SH, SRC_EWEN, 1'b0);
                    4'd1: s = mk_seg(SEG_DS, SRC_MAIN, 1'b0);
                    4'd2: s = mk_seg(SEG_SH, SRC_EWEN, 1'b1);
                    4'd3: s = mk_seg(SEG_DS, SRC_MAIN, 1'b0);
                    4'd4: s = mk_seg(SEG_SH, SRC_PCLR, 1'b1);
                    4'd5: s = mk_seg(SEG_DS, SRC_MAIN, 1'b0);
                    4'd6: s = mk_seg(SEG_PL, SRC_MAIN, 1'b0);
                    default: s = mk_seg(SEG_END, SRC_MAIN, 1'b0);
                endcase
            end
            default: s = mk_seg(SEG_END, SRC_MAIN, 1'b0);
        endcase
        return s;
    endfunction

endpackage

>>> rtl/mwe_front.sv
// Front end: decodes an incoming transaction and builds the command word it would start.
`timescale 1ns / 1ps

module mwe_front #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  logic [1:0]     req_type,
    input  logic [7:0]     address,
    input  logic [15:0]    write_data,
    input  logic           data_in_pin,
    output mwe_pkg::item_t item
);

    logic [ADDR_BITS-1:0] addr_m;
    logic [DATA_BITS-1:0] wdat_m;

    assign addr_m = address[ADDR_BITS-1:0];
    assign wdat_m = write_data[DATA_BITS-1:0];

    always_comb begin
        item.req = req_type;
        item.din = data_in_pin;
        unique case (req_type)
            mwe_pkg::REQ_READ:  item.cmd = mwe_pkg::CMD_MAX_W'({mwe_pkg::OP_READ, addr_m});
            mwe_pkg::REQ_WRITE: item.cmd = mwe_pkg::CMD_MAX_W'({mwe_pkg::OP_WRITE, addr_m,
                                                                wdat_m});
            default:            item.cmd = '0;
        endcase
    end

endmodule

>>> rtl/mwe_queue.sv
// Two-entry queue that decouples the front end from the sequencer.
`timescale 1ns / 1ps

module mwe_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mwe_pkg::item_t push_item,
    output logic           not_full,
    input  logic           pop,
    output logic           not_empty,
    output mwe_pkg::item_t head_item
);

    mwe_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/mwe_back.sv
// Back end: the pin sequencer, the phase timing register and the result register.
`timescale 1ns / 1ps

module mwe_back #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [7:0]     cfg_wr_data,
    input  logic           item_valid,
    input  mwe_pkg::item_t item,
    output logic           item_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [23:0]    m_tdata
);

    localparam int LEN_CMD  = 3 + ADDR_BITS;
    localparam int LEN_WR   = 3 + ADDR_BITS + DATA_BITS;
    localparam int BCW      = $clog2(LEN_WR + 1);
    localparam int CMD_IW   = $clog2(LEN_WR);
    localparam int CONST_IW = $clog2(LEN_CMD);
    localparam int SW       = mwe_pkg::STEP_W;

    logic [7:0]           ticks_cfg_reg;
    logic [SW-1:0]        state_reg, state_e, state_next;
    logic [LEN_WR-1:0]    cmd_reg, cmd_e;
    logic [BCW-1:0]       bc_reg, bc_e, bc_next, bc_inc, seg_len;
    logic [7:0]           pc_reg, pc_e, pc_next;
    logic [1:0]           sp_reg, sp_e, sp_next;
    logic [DATA_BITS-1:0] rs_reg, rs_e, rs_next;
    logic [1:0]           kind_reg, kind_e;
    mwe_pkg::pins_t       pins_reg, pins_next;
    logic                 out_valid_reg;
    logic [23:0]          out_data_reg;

    logic                 start, active, phase_end, seg_done, done, fire, out_free;
    logic [7:0]           ticks;
    logic [8:0]           pc_inc;
    logic [BCW-1:0]       main_idx, const_idx;
    logic [LEN_CMD-1:0]   const_word;
    logic                 tx_bit;
    mwe_pkg::seg_t        seg, nxt_seg;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = item_valid && out_free;
    assign item_pop = fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        start  = (state_reg == '0) && (item.req != mwe_pkg::REQ_TICK);
        kind_e = start ? item.req : kind_reg;
        cmd_e  = cmd_reg;
        rs_e   = rs_reg;
        if (start && (item.req == mwe_pkg::REQ_READ || item.req == mwe_pkg::REQ_WRITE)) begin
            cmd_e = item.cmd[LEN_WR-1:0];
        end
        if (start && item.req == mwe_pkg::REQ_READ) begin
            rs_e = '0;
        end
        state_e = start ? SW'(1) : state_reg;
        bc_e    = start ? '0 : bc_reg;
        sp_e    = start ? 2'd0 : sp_reg;
        pc_e    = start ? 8'd0 : pc_reg;
        active  = (state_e != '0);
        seg     = mwe_pkg::prog_seg(kind_e, state_e - SW'(1));
    end

    always_comb begin
        if (seg.src == mwe_pkg::SRC_MAIN && kind_e == mwe_pkg::REQ_WRITE) begin
            seg_len = BCW'(LEN_WR);
        end else begin
            seg_len = BCW'(LEN_CMD);
        end
        main_idx  = seg_len - BCW'(1) - bc_e;
        const_idx = BCW'(LEN_CMD - 1) - bc_e;
        unique case (seg.src)
            mwe_pkg::SRC_EWEN: const_word = {mwe_pkg::OP_EXT, {ADDR_BITS{1'b1}}};
            mwe_pkg::SRC_EWDS: const_word = {mwe_pkg::OP_EXT, {ADDR_BITS{1'b0}}};
            mwe_pkg::SRC_PCLR: const_word = {mwe_pkg::OP_PCLR, {ADDR_BITS{1'b1}}};
            default:           const_word = '0;
        endcase
        if (seg.src == mwe_pkg::SRC_MAIN) begin
            tx_bit = cmd_e[main_idx[CMD_IW-1:0]];
        end else begin
            tx_bit = const_word[const_idx[CONST_IW-1:0]];
        end
    end

    always_comb begin
        pins_next = '0;
        unique case (seg.kind)
            mwe_pkg::SEG_SH: begin
                pins_next.cs   = 1'b1;
                pins_next.de   = 1'b1;
                pins_next.dout = tx_bit;
                pins_next.clk  = (sp_e == 2'd1);
                pins_next.pr   = seg.pr;
            end
            mwe_pkg::SEG_RD: begin
                pins_next.cs  = 1'b1;
                pins_next.clk = (sp_e == 2'd0);
            end
            mwe_pkg::SEG_PL: begin
                pins_next.cs = 1'b1;
            end
            default: begin
                pins_next = '0;
            end
        endcase
        if (!active) begin
            pins_next = pins_reg;
        end
    end

    always_comb begin
        ticks      = (ticks_cfg_reg == 8'd0) ? 8'd1 : ticks_cfg_reg;
        pc_inc     = {1'b0, pc_e} + 9'd1;
        phase_end  = active && !(pc_inc < {1'b0, ticks});
        bc_inc     = bc_e + BCW'(1);
        pc_next    = phase_end ? 8'd0 : (active ? pc_inc[7:0] : pc_e);
        sp_next    = sp_e;
        bc_next    = bc_e;
        rs_next    = rs_e;
        state_next = state_e;
        seg_done   = 1'b0;
        done       = 1'b0;
        if (phase_end) begin
            unique case (seg.kind)
                mwe_pkg::SEG_SH: begin
                    if (sp_e == 2'd2) begin
                        sp_next = 2'd0;
                        if (bc_inc >= seg_len) begin
                            seg_done = 1'b1;
                        end else begin
                            bc_next = bc_inc;
                        end
                    end else begin
                        sp_next = sp_e + 2'd1;
                    end
                end
                mwe_pkg::SEG_RD: begin
                    if (sp_e == 2'd0) begin
                        rs_next = {rs_e[DATA_BITS-2:0], item.din};
                        sp_next = 2'd1;
                    end else begin
                        sp_next = 2'd0;
                        if (bc_inc >= BCW'(DATA_BITS)) begin
                            seg_done = 1'b1;
                        end else begin
                            bc_next = bc_inc;
                        end
                    end
                end
                mwe_pkg::SEG_PL: begin
                    seg_done = item.din;
                end
                default: begin
                    seg_done = 1'b1;
                end
            endcase
            if (seg_done) begin
                state_next = state_e + SW'(1);
                bc_next    = '0;
                sp_next    = 2'd0;
            end
        end
        nxt_seg = mwe_pkg::prog_seg(kind_e, state_next - SW'(1));
        if (phase_end && nxt_seg.kind == mwe_pkg::SEG_END) begin
            state_next = '0;
            bc_next    = '0;
            sp_next    = 2'd0;
            done       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {1'b0, 16'(rs_next), done, active,
                             pins_next.pr, pins_next.de, pins_next.dout,
                             pins_next.clk, pins_next.cs};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_cfg_reg <= 8'd4;
            state_reg     <= '0;
            cmd_reg       <= '0;
            bc_reg        <= '0;
            pc_reg        <= 8'd0;
            sp_reg        <= 2'd0;
            rs_reg        <= '0;
            kind_reg      <= mwe_pkg::REQ_TICK;
            pins_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ticks_cfg_reg <= cfg_wr_data;
            end
            if (fire) begin
                state_reg <= state_next;
                cmd_reg   <= cmd_e;
                bc_reg    <= bc_next;
                pc_reg    <= pc_next;
                sp_reg    <= sp_next;
                rs_reg    <= rs_next;
                kind_reg  <= kind_e;
                pins_reg  <= pins_next;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/microwire_eeprom_master_top.sv
// Top level of the Microwire serial EEPROM master.
`timescale 1ns / 1ps

// Each input transaction is one tick of the pin sequencer and yields exactly one output
// transaction carrying the pin levels, busy, done and the read shift register. A request
// (read, write or protection release) taken while idle starts its pin programme; requests
// arriving while busy are treated as plain ticks. Every pin phase lasts phase_ticks input
// transactions (zero acts as one); it is written through cfg_wr_en and cfg_wr_data only
// while the block is idle, a rule for the user that the block itself does not enforce. It
// sustains one transaction per clock while the output is not stalled: a two-entry queue
// sits between the decoder and the sequencer, and the result register is refilled in the
// cycle it is drained, so the rate is set by the sequencer's single state update per clock.
module microwire_eeprom_master_top #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[1:0], address[9:2], write_data[25:10], data_in_pin[26], zero[31:27]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // chip_select[0], serial_clock[1], data_out_pin[2], data_drive_enable[3],
    // protect_enable[4], busy_res[5], done_res[6], read_word[22:7], zero[23]
    output logic [23:0] m_tdata
);

    mwe_pkg::item_t dec_item;
    mwe_pkg::item_t head_item;
    logic           q_not_full;
    logic           q_not_empty;
    logic           q_pop;

    assign s_tready = q_not_full;

    mwe_front #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .req_type    (s_tdata[1:0]),
        .address     (s_tdata[9:2]),
        .write_data  (s_tdata[25:10]),
        .data_in_pin (s_tdata[26]),
        .item        (dec_item)
    );

    mwe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && q_not_full),
        .push_item (dec_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    mwe_back #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (q_not_empty),
        .item        (head_item),
        .item_pop    (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the Microwire EEPROM master: reads, writes and unprotect.
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT  = 5000;
    localparam int ITEM_TARGET = 900;

    typedef enum int {DIN_RANDOM, DIN_ONES, DIN_ZEROS, DIN_SPARSE} din_mode_t;

    // Predicts the pin levels, busy, done and read word for every tick and checks them.
    class microwire_pin_model;
        bit [7:0]       phase_ticks;
        int unsigned    prog_step;
        bit [26:0]      cmd_word;
        int unsigned    bit_idx;
        int unsigned    tick_cnt;
        int unsigned    sub_ph;
        bit [15:0]      read_sr;
        logic [1:0]     kind;
        mwe_pkg::pins_t pins;
        bit [23:0]      pin_levels_q[$];
        int             errors;

        function new();
            phase_ticks = 8'd4;
            prog_step   = 0;
            cmd_word    = '0;
            bit_idx     = 0;
            tick_cnt    = 0;
            sub_ph      = 0;
            read_sr     = '0;
            kind        = mwe_pkg::REQ_TICK;
            pins        = '0;
            errors      = 0;
        endfunction

        function bit idle();
            return prog_step == 0;
        endfunction

        function mwe_pkg::seg_t segment();
            mwe_pkg::seg_t s;
            s.kind = mwe_pkg::SEG_END;
            s.src  = mwe_pkg::SRC_MAIN;
            s.pr   = 1'b0;
            if (prog_step == 0) return s;
            case (kind)
                mwe_pkg::REQ_READ: begin
                    case (prog_step)
                        1: s.kind = mwe_pkg::SEG_SH;
                        2: s.kind = mwe_pkg::SEG_RD;
                        3: s.kind = mwe_pkg::SEG_DS;
                        default: ;
                    endcase
                end
                mwe_pkg::REQ_WRITE: begin
                    case (prog_step)
                        1: begin
                            s.kind = mwe_pkg::SEG_SH;
                            s.src  = mwe_pkg::SRC_EWEN;
                        end
                        2, 4, 6, 8: s.kind = mwe_pkg::SEG_DS;
                        3: s.kind = mwe_pkg::SEG_SH;
                        5: s.kind = mwe_pkg::SEG_PL;
                        7: begin
                            s.kind = mwe_pkg::SEG_SH;
                            s.src  = mwe_pkg::SRC_EWDS;
                        end
                        default: ;
                    endcase
                end
                mwe_pkg::REQ_UNPROT: begin
                    case (prog_step)
                        1: begin
                            s.kind = mwe_pkg::SEG_SH;
                            s.src  = mwe_pkg::SRC_EWEN;
                        end
                        2, 4, 6: s.kind = mwe_pkg::SEG_DS;
                        3: begin
                            s.kind = mwe_pkg::SEG_SH;
                            s.src  = mwe_pkg::SRC_EWEN;
                            s.pr   = 1'b1;
                        end
                        5: begin
                            s.kind = mwe_pkg::SEG_SH;
                            s.src  = mwe_pkg::SRC_PCLR;
                            s.pr   = 1'b1;
                        end
                        7: s.kind = mwe_pkg::SEG_PL;
                        default: ;
                    endcase
                end
                default: ;
            endcase
            return s;
        endfunction

        function int unsigned cmd_len(logic [1:0] src);
            return (src == mwe_pkg::SRC_MAIN && kind == mwe_pkg::REQ_WRITE) ? 27 : 11;
        endfunction

        function bit cmd_bit(logic [1:0] src, int unsigned idx);
            bit [26:0] v;
            int unsigned len;
            len = cmd_len(src);
            case (src)
                mwe_pkg::SRC_MAIN: v = cmd_word;
                mwe_pkg::SRC_EWEN: v = {16'b0, mwe_pkg::OP_EXT, 8'hFF};
                mwe_pkg::SRC_EWDS: v = {16'b0, mwe_pkg::OP_EXT, 8'h00};
                default:           v = {16'b0, mwe_pkg::OP_PCLR, 8'hFF};
            endcase
            return v[len - 1 - idx];
        endfunction

        function void advance();
            prog_step++;
            bit_idx  = 0;
            sub_ph   = 0;
            tick_cnt = 0;
        endfunction

        function void note_tick(bit [31:0] word);
            logic [1:0]    req;
            bit [7:0]      addr;
            bit [15:0]     wdata;
            bit            din;
            int unsigned   ticks;
            bit            busy;
            bit            done;
            mwe_pkg::seg_t s;
            req   = word[1:0];
            addr  = word[9:2];
            wdata = word[25:10];
            din   = word[26];
            ticks = (phase_ticks == 0) ? 1 : phase_ticks;
            busy  = 1'b0;
            done  = 1'b0;
            if (prog_step == 0 && req != mwe_pkg::REQ_TICK) begin
                kind = req;
                if (req == mwe_pkg::REQ_READ) begin
                    cmd_word = {16'b0, mwe_pkg::OP_READ, addr};
                    read_sr  = '0;
                end else if (req == mwe_pkg::REQ_WRITE) begin
                    cmd_word = {mwe_pkg::OP_WRITE, addr, wdata};
                end
                prog_step = 1;
                bit_idx   = 0;
                sub_ph    = 0;
                tick_cnt  = 0;
            end
            if (prog_step != 0) begin
                s    = segment();
                busy = 1'b1;
                pins = '0;
                case (s.kind)
                    mwe_pkg::SEG_SH: begin
                        pins.cs   = 1'b1;
                        pins.de   = 1'b1;
                        pins.dout = cmd_bit(s.src, bit_idx);
                        pins.clk  = (sub_ph == 1);
                        pins.pr   = s.pr;
                    end
                    mwe_pkg::SEG_RD: begin
                        pins.cs  = 1'b1;
                        pins.clk = (sub_ph == 0);
                    end
                    mwe_pkg::SEG_PL: pins.cs = 1'b1;
                    default: ;
                endcase
                if (tick_cnt + 1 < ticks) begin
                    tick_cnt++;
                end else begin
                    tick_cnt = 0;
                    case (s.kind)
                        mwe_pkg::SEG_SH: begin
                            sub_ph++;
                            if (sub_ph >= 3) begin
                                sub_ph = 0;
                                bit_idx++;
                                if (bit_idx >= cmd_len(s.src)) advance();
                            end
                        end
                        mwe_pkg::SEG_RD: begin
                            if (sub_ph == 0) begin
                                read_sr = {read_sr[14:0], din};
                                sub_ph  = 1;
                            end else begin
                                sub_ph = 0;
                                bit_idx++;
                                if (bit_idx >= 16) advance();
                            end
                        end
                        mwe_pkg::SEG_PL: if (din) advance();
                        default: advance();
                    endcase
                    s = segment();
                    if (s.kind == mwe_pkg::SEG_END) begin
                        prog_step = 0;
                        bit_idx   = 0;
                        sub_ph    = 0;
                        done      = 1'b1;
                    end
                end
            end
            pin_levels_q.push_back({1'b0, read_sr, done, busy, pins});
        endfunction

        function void check_pins(logic [23:0] got);
            bit [23:0] exp_word;
            string names[7] = '{"chip_select", "serial_clock", "data_out_pin",
                                "data_drive_enable", "protect_enable", "busy_res",
                                "done_res"};
            if (pin_levels_q.size() == 0) begin
                $display("%0t: unexpected output transaction %h", $time, got);
                errors++;
                return;
            end
            exp_word = pin_levels_q.pop_front();
            for (int i = 0; i < 7; i++) begin
                if (got[i] !== exp_word[i]) begin
                    $display("%0t: %s expected %0d, got %0d", $time, names[i],
                             exp_word[i], got[i]);
                    errors++;
                end
            end
            if (got[22:7] !== exp_word[22:7]) begin
                $display("%0t: read_word expected %h, got %h", $time, exp_word[22:7],
                         got[22:7]);
                errors++;
            end
            if (got[23] !== 1'b0) begin
                $display("%0t: padding bit expected 0, got %b", $time, got[23]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    microwire_pin_model pin_model;
    bit          calm;
    int          stall_left;
    int          idle_cycles;
    int unsigned items_sent;
    int          pick;

    microwire_eeprom_master_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit din_for(din_mode_t mode);
        case (mode)
            DIN_ONES:   return 1'b1;
            DIN_ZEROS:  return 1'b0;
            DIN_SPARSE: return $urandom_range(0, 7) == 0;
            default:    return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic bit [7:0] pick_ticks();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'd1;
        if (r < 8) return 8'd2;
        if (r == 8) return 8'd3;
        return 8'($urandom_range(0, 6));
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) pin_model.check_pins(m_tdata);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[microwire_eeprom_master_top] ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] req, input bit [7:0] addr,
                             input bit [15:0] data, input bit din);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, din, data, addr, req};
        do @(posedge aclk); while (!s_tready);
        pin_model.note_tick({5'b0, din, data, addr, req});
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic idle_ticks(input int count);
        repeat (count) begin
            send_item(mwe_pkg::REQ_TICK, 8'($urandom), 16'($urandom),
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_request(input logic [1:0] req, input bit [7:0] addr,
                               input bit [15:0] data, input din_mode_t mode);
        logic [1:0] tick_req;
        send_item(req, addr, data, din_for(mode));
        while (!pin_model.idle()) begin
            // Requests arriving mid-sequence must be ignored.
            tick_req = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3))
                                                    : mwe_pkg::REQ_TICK;
            send_item(tick_req, 8'($urandom), 16'($urandom), din_for(mode));
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pin_model.pin_levels_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_cfg(input bit [7:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        pin_model.phase_ticks = value;
    endtask

    initial begin
        pin_model   = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'd0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        calm        = 1'b1;
        stall_left  = 0;
        idle_cycles = 0;
        items_sent  = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset value of the phase length.
        idle_ticks(6);
        run_request(mwe_pkg::REQ_READ, 8'hFF, 16'h0000, DIN_RANDOM);
        idle_ticks(3);
        settle();

        // A phase length of zero behaves as one.
        write_cfg(8'd0);
        calm = 1'b0;
        run_request(mwe_pkg::REQ_READ, 8'h00, 16'hFFFF, DIN_ONES);
        run_request(mwe_pkg::REQ_READ, 8'hA5, 16'h5A5A, DIN_ZEROS);
        run_request(mwe_pkg::REQ_WRITE, 8'hFF, 16'h0000, DIN_SPARSE);
        run_request(mwe_pkg::REQ_UNPROT, 8'h3C, 16'hC3C3, DIN_RANDOM);
        idle_ticks(4);
        settle();
        write_cfg(8'd1);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 5) == 0) begin
                settle();
                write_cfg(pick_ticks());
                calm = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                idle_ticks($urandom_range(1, 8));
            end else if (pick < 4) begin
                run_request(mwe_pkg::REQ_READ, 8'($urandom), 16'($urandom),
                            din_mode_t'($urandom_range(0, 3)));
            end else if (pick < 7) begin
                run_request(mwe_pkg::REQ_WRITE, 8'($urandom), 16'($urandom),
                            ($urandom_range(0, 3) == 0) ? DIN_SPARSE : DIN_RANDOM);
            end else begin
                run_request(mwe_pkg::REQ_UNPROT, 8'($urandom), 16'($urandom),
                            ($urandom_range(0, 3) == 0) ? DIN_SPARSE : DIN_RANDOM);
            end
        end

        s_tvalid <= 1'b0;
        while (pin_model.pin_levels_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pin_model.errors == 0) begin
            $display("[microwire_eeprom_master_top] OK");
        end else begin
            $display("[microwire_eeprom_master_top] ERROR");
        end
        $finish;
    end

endmodule
